// File: rtl/core/double_ended_queue_defines.svh
// Assertion helpers for the checker file deq_checker.sv.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Check on every rising edge of clk, muted while rst is high.
`define DEQ_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) cond) else $error(msg);

// Check on every rising edge of clk, reset included.
`define DEQ_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) cond) else $error(msg);

`endif

// File: rtl/core/deq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  typedef enum logic [2:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_POP_BACK   = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_CLEAR      = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_FETCH = 1'b1
  } state_t;

  typedef struct packed {
    logic exec;
    logic load;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/deq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output deq_pkg::ctrl_cmd_t     cmd
);
  import deq_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.exec   = 1'b1;
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        // hold the read data until the result register frees up
        if (!out_valid || out_ready) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (cmd.load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/deq_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module deq_dp #(
  parameter int DEPTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  deq_pkg::ctrl_cmd_t      cmd,
  input  wire logic [2:0]         action,
  input  wire logic signed [31:0] value,
  output logic [1:0]              status,
  output logic [5:0]              count,
  output logic                    ends_valid,
  output logic signed [31:0]      front_value,
  output logic signed [31:0]      back_value
);
  import deq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] i);
    return (i == LAST_SLOT) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] i);
    return (i == '0) ? LAST_SLOT : i - AW'(1);
  endfunction

  logic [31:0]   mem [DEPTH];

  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic [AW-1:0] tail;
  logic [AW-1:0] tail_next;
  logic [CW-1:0] fill;
  logic [CW-1:0] fill_next;
  status_t       st;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] front_addr;
  logic [AW-1:0] back_addr;

  logic [31:0]   rd_front;
  logic [31:0]   rd_back;
  logic          byp_front;
  logic          byp_back;
  logic [31:0]   byp_value;
  status_t       pend_status;
  logic [CW-1:0] pend_fill;

  always_comb begin
    head_next = head;
    tail_next = tail;
    fill_next = fill;
    st        = ST_OK;
    wr_en     = 1'b0;
    wr_addr   = tail;
    case (action)
      ACT_PUSH_BACK: begin
        if (fill == FULL_CNT) begin
          st = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = tail;
          tail_next = slot_inc(tail);
          fill_next = fill + CW'(1);
        end
      end
      ACT_PUSH_FRONT: begin
        if (fill == FULL_CNT) begin
          st = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = slot_dec(head);
          head_next = slot_dec(head);
          fill_next = fill + CW'(1);
        end
      end
      ACT_POP_BACK: begin
        if (fill == '0) begin
          st = ST_EMPTY;
        end else begin
          tail_next = slot_dec(tail);
          fill_next = fill - CW'(1);
        end
      end
      ACT_POP_FRONT: begin
        if (fill == '0) begin
          st = ST_EMPTY;
        end else begin
          head_next = slot_inc(head);
          fill_next = fill - CW'(1);
        end
      end
      ACT_CLEAR: begin
        if (fill == '0) begin
          st = ST_EMPTY;
        end else begin
          head_next = '0;
          tail_next = '0;
          fill_next = '0;
        end
      end
      default: ;
    endcase
    front_addr = head_next;
    back_addr  = slot_dec(tail_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else if (cmd.exec) begin
      head <= head_next;
      tail <= tail_next;
      fill <= fill_next;
    end
  end

  // Storage and both end reads; a push lands on an end being read, so bypass it.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (wr_en) begin
        mem[wr_addr] <= value;
      end
      rd_front    <= mem[front_addr];
      rd_back     <= mem[back_addr];
      byp_front   <= wr_en && (wr_addr == front_addr);
      byp_back    <= wr_en && (wr_addr == back_addr);
      byp_value   <= value;
      pend_status <= st;
      pend_fill   <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status     <= pend_status;
      count      <= 6'(pend_fill);
      ends_valid <= (pend_fill != '0);
      if (pend_fill != '0) begin
        front_value <= byp_front ? byp_value : rd_front;
        back_value  <= byp_back ? byp_value : rd_back;
      end else begin
        front_value <= '0;
        back_value  <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/double_ended_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Bounded double-ended queue of signed 32-bit values in a DEPTH-entry circular
// buffer. Each input transaction (push back, push front, pop back, pop front,
// clear) yields one result transaction with status, element count and both
// end values. In the accept cycle (S_IDLE) the head, tail and count are
// updated, a pushed value is written and the two end reads of the
// synchronous storage are launched; S_FETCH then moves the read data into the
// result register once that register is free. The result register lets the
// next item be accepted while a result waits for out_ready. The storage needs
// no clearing after reset; a push onto a full queue returns status full and
// changes nothing, and a pop or clear on an empty queue returns status empty.
// count carries the low 6 bits of the element count.
module double_ended_queue #(
  parameter int DEPTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         action,
  input  wire logic signed [31:0] value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              status,
  output logic [5:0]              count,
  output logic                    ends_valid,
  output logic signed [31:0]      front_value,
  output logic signed [31:0]      back_value
);
  import deq_pkg::*;

  ctrl_cmd_t cmd;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  deq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .action      (action),
    .value       (value),
    .status      (status),
    .count       (count),
    .ends_valid  (ends_valid),
    .front_value (front_value),
    .back_value  (back_value)
  );

endmodule

`default_nettype wire

// File: rtl/core/deq_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "double_ended_queue_defines.svh"

module deq_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [1:0]         status,
  input wire logic [5:0]         count,
  input wire logic               ends_valid,
  input wire logic signed [31:0] front_value,
  input wire logic signed [31:0] back_value
);
  import deq_pkg::*;

  `DEQ_ASSERT_ALWAYS(a_reset_quiet, rst |=> (!out_valid && in_ready), "result pending after reset")
  `DEQ_ASSERT(a_one_at_a_time, (in_valid && in_ready) |=> !in_ready, "accepted during fetch")
  `DEQ_ASSERT(a_empty_ends_zero, (out_valid && !ends_valid) |-> (front_value == 32'sd0 && back_value == 32'sd0), "ends not zero on empty queue")
  `DEQ_ASSERT(a_status_ends, (out_valid && status == ST_EMPTY) |-> !ends_valid, "empty status with valid ends")
  `DEQ_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(count) && $stable(status)), "stalled result changed")

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

`default_nettype wire
